// ===== rtl/core/bbp_pkg.sv =====
`timescale 1ns / 1ps
// Package for the bimodal branch predictor: transaction types and shared constants.
// Depends on nothing; every other file in rtl/core uses it by scoped names.
package bbp_pkg;

    localparam int INDEX_BITS_DEFAULT = 10;
    localparam int ADDR_W = 32;
    localparam int STAT_W = 32;
    localparam int CTR_W = 2;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CTR_W-1:0] CTR_STRONG_NOT_TAKEN = 2'd0;
    localparam logic [CTR_W-1:0] CTR_STRONG_TAKEN = 2'd3;
    localparam logic [STAT_W-1:0] STAT_MAX = '1;

    typedef struct packed {
        logic [ADDR_W-1:0] branch_address;
        logic              actual_taken;
    } branch_item_t;

    typedef struct packed {
        logic              predicted_taken;
        logic              prediction_correct;
        logic [STAT_W-1:0] hits_taken;
        logic [STAT_W-1:0] misses_taken;
        logic [STAT_W-1:0] hits_not_taken;
        logic [STAT_W-1:0] misses_not_taken;
    } result_item_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

// ===== rtl/core/bbp_front.sv =====
`timescale 1ns / 1ps
// Front stage of the bimodal branch predictor: accepts branch transactions and
// reduces each to a table index and outcome. Depends on bbp_pkg.
module bbp_front #(
    parameter int IndexBits = bbp_pkg::INDEX_BITS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     branch_valid,
    output logic                     branch_ready,
    input  bbp_pkg::branch_item_t    branch,
    input  bbp_pkg::back_status_t    status,
    output logic                     push_valid,
    input  logic                     push_ready,
    output logic [IndexBits:0]       push_data
);

    logic               valid_reg;
    logic               valid_next;
    logic [IndexBits:0] entry_reg;
    logic               accept;

    assign branch_ready = !status.clearing && (!valid_reg || push_ready);
    assign accept       = branch_valid && branch_ready;
    assign push_valid   = valid_reg;
    assign push_data    = entry_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_reg <= {branch.branch_address[IndexBits-1:0], branch.actual_taken};
        end
    end

endmodule

// ===== rtl/core/bbp_queue.sv =====
`timescale 1ns / 1ps
// Short queue between the front and back stages of the bimodal branch predictor.
// Depends on bbp_pkg for its depth.
module bbp_queue #(
    parameter int DataW = bbp_pkg::INDEX_BITS_DEFAULT + 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [DataW-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [DataW-1:0] pop_data
);

    localparam int Depth = bbp_pkg::QUEUE_DEPTH;
    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCount = CntW'(Depth);

    logic [DataW-1:0] entries_reg [0:Depth-1];
    logic [PtrW-1:0]  wr_ptr_reg;
    logic [PtrW-1:0]  wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg;
    logic [PtrW-1:0]  rd_ptr_next;
    logic [CntW-1:0]  count_reg;
    logic [CntW-1:0]  count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != FullCount);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/bbp_back.sv =====
`timescale 1ns / 1ps
// Back stage of the bimodal branch predictor: counter table memory, statistics
// counters and the result register. Depends on bbp_pkg.
module bbp_back #(
    parameter int IndexBits = bbp_pkg::INDEX_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  logic [IndexBits:0]    pop_data,
    output bbp_pkg::back_status_t status,
    output logic                  result_valid,
    input  logic                  result_ready,
    output bbp_pkg::result_item_t result
);

    localparam int TableDepth = 1 << IndexBits;
    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;
    localparam logic [IndexBits-1:0] LastIndex = '1;

    function automatic logic [bbp_pkg::STAT_W-1:0] sat_inc(
        input logic [bbp_pkg::STAT_W-1:0] v
    );
        sat_inc = (v == bbp_pkg::STAT_MAX) ? v : v + 1'b1;
    endfunction

    logic [bbp_pkg::CTR_W-1:0] table_mem [0:TableDepth-1];
    logic [bbp_pkg::CTR_W-1:0] rd_data_reg;

    logic [1:0]                 state_reg;
    logic [1:0]                 state_next;
    logic [IndexBits-1:0]       clr_idx_reg;
    logic [IndexBits-1:0]       clr_idx_next;
    logic [IndexBits-1:0]       cur_idx_reg;
    logic                       cur_taken_reg;

    logic [bbp_pkg::STAT_W-1:0] hit_t_reg;
    logic [bbp_pkg::STAT_W-1:0] hit_t_next;
    logic [bbp_pkg::STAT_W-1:0] miss_t_reg;
    logic [bbp_pkg::STAT_W-1:0] miss_t_next;
    logic [bbp_pkg::STAT_W-1:0] hit_nt_reg;
    logic [bbp_pkg::STAT_W-1:0] hit_nt_next;
    logic [bbp_pkg::STAT_W-1:0] miss_nt_reg;
    logic [bbp_pkg::STAT_W-1:0] miss_nt_next;

    logic                       res_valid_reg;
    logic                       res_valid_next;
    bbp_pkg::result_item_t      res_reg;
    bbp_pkg::result_item_t      res_next;

    logic                       out_free;
    logic                       do_read;
    logic                       do_update;
    logic                       pred;
    logic                       correct;
    logic [bbp_pkg::CTR_W-1:0]  ctr_new;
    logic                       wr_en;
    logic [IndexBits-1:0]       wr_addr;
    logic [bbp_pkg::CTR_W-1:0]  wr_data;

    assign status.clearing = (state_reg == ST_CLEAR);
    assign pop_ready       = (state_reg == ST_IDLE);
    assign do_read         = pop_valid && pop_ready;
    assign out_free        = !res_valid_reg || result_ready;
    assign do_update       = (state_reg == ST_UPDATE) && out_free;
    assign result_valid    = res_valid_reg;
    assign result          = res_reg;

    assign pred    = rd_data_reg[bbp_pkg::CTR_W-1];
    assign correct = (pred == cur_taken_reg);

    always_comb
    begin
        if (cur_taken_reg)
        begin
            ctr_new = (rd_data_reg == bbp_pkg::CTR_STRONG_TAKEN) ?
                      rd_data_reg : rd_data_reg + 1'b1;
        end
        else
        begin
            ctr_new = (rd_data_reg == bbp_pkg::CTR_STRONG_NOT_TAKEN) ?
                      rd_data_reg : rd_data_reg - 1'b1;
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cur_idx_reg;
        wr_data = ctr_new;
        if (state_reg == ST_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_idx_reg;
            wr_data = bbp_pkg::CTR_STRONG_NOT_TAKEN;
        end
        else if (do_update)
        begin
            wr_en = 1'b1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        hit_t_next     = hit_t_reg;
        miss_t_next    = miss_t_reg;
        hit_nt_next    = hit_nt_reg;
        miss_nt_next   = miss_nt_reg;
        res_valid_next = res_valid_reg && !result_ready;
        res_next       = res_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == LastIndex)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (do_read)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (do_update)
                begin
                    if (cur_taken_reg && correct)
                    begin
                        hit_t_next = sat_inc(hit_t_reg);
                    end
                    if (cur_taken_reg && !correct)
                    begin
                        miss_t_next = sat_inc(miss_t_reg);
                    end
                    if (!cur_taken_reg && correct)
                    begin
                        hit_nt_next = sat_inc(hit_nt_reg);
                    end
                    if (!cur_taken_reg && !correct)
                    begin
                        miss_nt_next = sat_inc(miss_nt_reg);
                    end
                    res_next.predicted_taken    = pred;
                    res_next.prediction_correct = correct;
                    res_next.hits_taken         = hit_t_next;
                    res_next.misses_taken       = miss_t_next;
                    res_next.hits_not_taken     = hit_nt_next;
                    res_next.misses_not_taken   = miss_nt_next;
                    res_valid_next              = 1'b1;
                    state_next                  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            hit_t_reg     <= '0;
            miss_t_reg    <= '0;
            hit_nt_reg    <= '0;
            miss_nt_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            hit_t_reg     <= hit_t_next;
            miss_t_reg    <= miss_t_next;
            hit_nt_reg    <= hit_nt_next;
            miss_nt_reg   <= miss_nt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (do_read)
        begin
            cur_idx_reg   <= pop_data[IndexBits:1];
            cur_taken_reg <= pop_data[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        if (do_read)
        begin
            rd_data_reg <= table_mem[pop_data[IndexBits:1]];
        end
    end

endmodule

// ===== rtl/core/bimodal_branch_predictor_top.sv =====
`timescale 1ns / 1ps
// Top level of the bimodal branch predictor: front stage, queue and back stage.
// Depends on bbp_pkg, bbp_front, bbp_queue and bbp_back.
//
// Each transaction on the branch channel carries a branch address and its
// resolved outcome. The low IndexBits bits of the address select a two-bit
// saturating counter; the result channel returns the prediction made before
// the update, whether it was correct, and the four saturating statistics
// counters as they stand after this transaction.
// A result goes from the front register through the queue and the back stage's
// counter read to the output register. The back stage reads the counter table
// and then writes it back for each transaction and takes no new one until the
// write is done; that read-modify-write sequence sets the sustained rate.
// After reset the table is swept to strongly not taken, one entry per cycle,
// and branch_ready stays low meanwhile. The statistics clear at once.
// When the receiver holds result_ready low, the finished result waits in the
// output register while up to four further transactions are taken into the
// front register, the queue and the back stage; branch_ready then falls.
module bimodal_branch_predictor_top #(
    parameter int IndexBits = bbp_pkg::INDEX_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  branch_valid,
    output logic                  branch_ready,
    input  bbp_pkg::branch_item_t branch,
    output logic                  result_valid,
    input  logic                  result_ready,
    output bbp_pkg::result_item_t result
);

    bbp_pkg::back_status_t status;
    logic                  push_valid;
    logic                  push_ready;
    logic [IndexBits:0]    push_data;
    logic                  pop_valid;
    logic                  pop_ready;
    logic [IndexBits:0]    pop_data;

    bbp_front #(
        .IndexBits(IndexBits)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .branch_valid(branch_valid),
        .branch_ready(branch_ready),
        .branch      (branch),
        .status      (status),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data)
    );

    bbp_queue #(
        .DataW(IndexBits + 1)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_data (push_data),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data)
    );

    bbp_back #(
        .IndexBits(IndexBits)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_data    (pop_data),
        .status      (status),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

endmodule

// ===== dv/bimodal_branch_predictor_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for bimodal_branch_predictor_top: directed and random branch traffic
// with random idling on both channels, checked against a two-bit counter table model.
// Depends on bbp_pkg and the RTL under rtl/core.
module bimodal_branch_predictor_top_tb;

    localparam int INDEX_BITS = bbp_pkg::INDEX_BITS_DEFAULT;
    localparam int TABLE_SIZE = 1 << INDEX_BITS;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int DIRECTED_COUNT = 20;

    localparam bbp_pkg::branch_item_t DIRECTED [DIRECTED_COUNT] = '{
        {32'h0000_0000, 1'b0}, {32'h0000_0000, 1'b1}, {32'h0000_0400, 1'b1},
        {32'hFFFF_FC00, 1'b1}, {32'h8000_0000, 1'b1}, {32'h1234_5400, 1'b0},
        {32'h0000_0000, 1'b0}, {32'h0000_0000, 1'b0}, {32'h0000_0000, 1'b0},
        {32'hFFFF_FFFF, 1'b1}, {32'h0000_03FF, 1'b1}, {32'hFFFF_FFFF, 1'b1},
        {32'h0000_03FF, 1'b0}, {32'hFFFF_FFFF, 1'b0}, {32'h5555_5555, 1'b1},
        {32'hAAAA_AAAA, 1'b0}, {32'h5555_5555, 1'b1}, {32'h5555_5555, 1'b1},
        {32'hAAAA_AAAA, 1'b1}, {32'h0000_0200, 1'b1}
    };

    class counter_table_model;
        logic [bbp_pkg::CTR_W-1:0]  counters [TABLE_SIZE];
        logic [bbp_pkg::STAT_W-1:0] hit_taken;
        logic [bbp_pkg::STAT_W-1:0] miss_taken;
        logic [bbp_pkg::STAT_W-1:0] hit_not_taken;
        logic [bbp_pkg::STAT_W-1:0] miss_not_taken;
        bbp_pkg::result_item_t      expected_results [$];
        int                         branches_seen;
        int                         taken_seen;
        int                         results_checked;
        int                         mismatches;

        function new();
            foreach (counters[i])
            begin
                counters[i] = bbp_pkg::CTR_STRONG_NOT_TAKEN;
            end
            hit_taken = '0;
            miss_taken = '0;
            hit_not_taken = '0;
            miss_not_taken = '0;
            branches_seen = 0;
            taken_seen = 0;
            results_checked = 0;
            mismatches = 0;
        endfunction

        function logic [bbp_pkg::STAT_W-1:0] bump(logic [bbp_pkg::STAT_W-1:0] count);
            return (count == bbp_pkg::STAT_MAX) ? count : count + 1'b1;
        endfunction

        function int outstanding();
            return expected_results.size();
        endfunction

        function void record_branch(bbp_pkg::branch_item_t item);
            logic [INDEX_BITS-1:0]     slot;
            logic [bbp_pkg::CTR_W-1:0] ctr;
            bbp_pkg::result_item_t     predicted;
            slot = item.branch_address[INDEX_BITS-1:0];
            ctr = counters[slot];
            predicted.predicted_taken = (ctr >= 2'd2);
            predicted.prediction_correct = (predicted.predicted_taken == item.actual_taken);
            if (item.actual_taken)
            begin
                taken_seen++;
                if (predicted.prediction_correct)
                    hit_taken = bump(hit_taken);
                else
                    miss_taken = bump(miss_taken);
                if (ctr != bbp_pkg::CTR_STRONG_TAKEN)
                    ctr = ctr + 1'b1;
            end
            else
            begin
                if (predicted.prediction_correct)
                    hit_not_taken = bump(hit_not_taken);
                else
                    miss_not_taken = bump(miss_not_taken);
                if (ctr != bbp_pkg::CTR_STRONG_NOT_TAKEN)
                    ctr = ctr - 1'b1;
            end
            counters[slot] = ctr;
            predicted.hits_taken = hit_taken;
            predicted.misses_taken = miss_taken;
            predicted.hits_not_taken = hit_not_taken;
            predicted.misses_not_taken = miss_not_taken;
            expected_results.insert(expected_results.size(), predicted);
            branches_seen++;
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_result(bbp_pkg::result_item_t got);
            bbp_pkg::result_item_t want;
            if (expected_results.size() == 0)
            begin
                report_mismatch("result transaction with no branch outstanding");
                return;
            end
            want = expected_results.pop_front();
            results_checked++;
            if (got.predicted_taken !== want.predicted_taken)
                report_mismatch($sformatf("result %0d predicted_taken %b, want %b",
                    results_checked, got.predicted_taken, want.predicted_taken));
            if (got.prediction_correct !== want.prediction_correct)
                report_mismatch($sformatf("result %0d prediction_correct %b, want %b",
                    results_checked, got.prediction_correct, want.prediction_correct));
            if (got.hits_taken !== want.hits_taken)
                report_mismatch($sformatf("result %0d hits_taken %0d, want %0d",
                    results_checked, got.hits_taken, want.hits_taken));
            if (got.misses_taken !== want.misses_taken)
                report_mismatch($sformatf("result %0d misses_taken %0d, want %0d",
                    results_checked, got.misses_taken, want.misses_taken));
            if (got.hits_not_taken !== want.hits_not_taken)
                report_mismatch($sformatf("result %0d hits_not_taken %0d, want %0d",
                    results_checked, got.hits_not_taken, want.hits_not_taken));
            if (got.misses_not_taken !== want.misses_not_taken)
                report_mismatch($sformatf("result %0d misses_not_taken %0d, want %0d",
                    results_checked, got.misses_not_taken, want.misses_not_taken));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  branch_valid;
    logic                  branch_ready;
    bbp_pkg::branch_item_t branch;
    logic                  result_valid;
    logic                  result_ready;
    bbp_pkg::result_item_t result;

    counter_table_model sb;
    bit                 no_idle;
    int                 cycle_count;

    bimodal_branch_predictor_top #(
        .IndexBits(INDEX_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .branch_valid(branch_valid),
        .branch_ready(branch_ready),
        .branch(branch),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result)
    );

    initial clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count == TIMEOUT_CYCLES);
        $display("Timed out after %0d cycles.", TIMEOUT_CYCLES);
        $display("FAIL bimodal_branch_predictor_top");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (branch_valid && branch_ready)
                sb.record_branch(branch);
            if (result_valid && result_ready)
                sb.check_result(result);
        end
    end

    task automatic send_branch(bbp_pkg::branch_item_t item);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            branch_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        branch_valid <= 1'b1;
        branch <= item;
        do @(posedge clk); while (!branch_ready);
    endtask

    task automatic send_random_branches(int count);
        bbp_pkg::branch_item_t item;
        logic [INDEX_BITS-1:0] slot;
        repeat (count)
        begin
            item.branch_address = $urandom();
            if ($urandom_range(0, 9) < 6)
            begin
                slot = INDEX_BITS'($urandom_range(0, 7));
                item.branch_address[INDEX_BITS-1:0] = slot;
                item.actual_taken = ($urandom_range(0, 9) < ((slot < 4) ? 8 : 3));
            end
            else
            begin
                item.actual_taken = 1'($urandom_range(0, 1));
            end
            send_branch(item);
        end
    endtask

    task automatic drain_results();
        branch_valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int stall;
        result_ready = 1'b0;
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 13);
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
        end
    end

    initial
    begin
        sb = new();
        no_idle = 1'b0;
        rst_n = 1'b0;
        branch_valid = 1'b0;
        branch = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i])
        begin
            send_branch(DIRECTED[i]);
        end
        send_random_branches(800);
        drain_results();

        no_idle = 1'b1;
        send_random_branches(400);
        drain_results();

        no_idle = 1'b0;
        send_random_branches(450);
        drain_results();
        repeat (16) @(posedge clk);

        $display("Covered %0d branch transactions (%0d directed, %0d taken) over hot and scattered",
            sb.branches_seen, DIRECTED_COUNT, sb.taken_seen);
        $display("table entries, with idle, back-to-back and drained phases; %0d results checked.",
            sb.results_checked);
        if (sb.mismatches == 0)
        begin
            $display("PASS bimodal_branch_predictor_top");
        end
        else
        begin
            $display("%0d mismatches found.", sb.mismatches);
            $display("FAIL bimodal_branch_predictor_top");
        end
        $finish;
    end

endmodule
